FILE: hw/rtl/fse_pkg.sv
package fse_pkg;

  // Field widths fixed by the command and result formats
  localparam int unsigned LenW   = 11;
  localparam int unsigned AddrW  = 10;
  localparam int unsigned DataW  = 32;
  localparam int unsigned IdxW   = 10;
  // Fibonacci terms stay below twice the largest length
  localparam int unsigned FibW   = LenW + 1;

  localparam logic [LenW-1:0] LenReset = LenW'(1024);

  localparam logic CmdWrite  = 1'b0;
  localparam logic CmdSearch = 1'b1;

  typedef struct packed {
    logic                    command;
    logic [AddrW-1:0]        entry_address;
    logic signed [DataW-1:0] entry_value;
    logic signed [DataW-1:0] search_key;
  } cmd_t;

  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] found_index;
  } res_t;

endpackage

FILE: hw/rtl/fibonacci_search_engine_core.sv
// Fibonacci search over a sorted table of signed values. A write command
// (start high while busy is low) stores one entry in that cycle and never
// raises busy; the next command may follow at once. A search raises busy and
// returns one result beat on result_valid_o, one cycle wide, which the
// receiver must take. A search holds busy through the growth steps of the
// Fibonacci terms until they reach the length, then through the probes, each
// of which needs one read of the single-port table memory and one compare,
// and through a last-entry check that reads the table when it applies; a
// probe that hits ends the search early. The table length register is
// written through cfg_we_i / cfg_wdata_i; the user is to write it only while
// the block is idle, which the block does not enforce. It resets to 1024.
module fibonacci_search_engine_core #(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  fse_pkg::cmd_t         cmd_i,
  input  logic                  cfg_we_i,
  input  logic [fse_pkg::LenW-1:0] cfg_wdata_i,
  output logic                  result_valid_o,
  output fse_pkg::res_t         result_o
);
  import fse_pkg::*;

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned XW = ((AW > FibW) ? AW : FibW) + 1;
  localparam int unsigned CW = (VALUE_WIDTH < DataW) ? VALUE_WIDTH : DataW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GROW,
    S_PROBE,
    S_CMP,
    S_FINAL
  } state_e;

  state_e                  state_q;
  logic [LenW-1:0]         len_q;
  logic [LenW-1:0]         n_q;
  logic [FibW-1:0]         f0_q, f1_q, f2_q;
  logic [FibW-1:0]         base_q;   // offset + 1
  logic [XW-1:0]           idx_q;
  logic signed [VALUE_WIDTH-1:0] key_q;
  logic                    res_valid_q;
  res_t                    res_q;

  logic signed [VALUE_WIDTH-1:0] mem [MAX_ENTRIES];
  logic signed [VALUE_WIDTH-1:0] rdata_q;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;

  logic                    accept;
  logic                    wr_en;
  logic [XW-1:0]           wr_idx;
  logic signed [VALUE_WIDTH-1:0] wr_val;
  logic signed [VALUE_WIDTH-1:0] key_ext;
  logic [LenW-1:0]         n_new;
  logic [XW-1:0]           probe_sum;
  logic [XW-1:0]           probe_idx;

  assign accept  = start && !busy;
  assign wr_idx  = XW'(cmd_i.entry_address);
  assign wr_en   = accept && (cmd_i.command == CmdWrite) && (wr_idx < XW'(MAX_ENTRIES));
  assign wr_val  = VALUE_WIDTH'($signed(cmd_i.entry_value[CW-1:0]));
  assign key_ext = VALUE_WIDTH'($signed(cmd_i.search_key[CW-1:0]));
  assign n_new   = (XW'(len_q) > XW'(MAX_ENTRIES)) ? LenW'(MAX_ENTRIES) : len_q;

  // probe index: offset + f2, clamped to [0, n-1]
  always_comb begin
    probe_sum = XW'(base_q) + XW'(f2_q);
    if (probe_sum == '0) begin
      probe_idx = '0;
    end else if (probe_sum > XW'(n_q)) begin
      probe_idx = XW'(n_q) - XW'(1);
    end else begin
      probe_idx = probe_sum - XW'(1);
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = probe_idx[AW-1:0];
    if (state_q == S_PROBE) begin
      if (f0_q > FibW'(1)) begin
        rd_en = 1'b1;
      end else begin
        rd_en   = (f1_q == FibW'(1)) && (base_q < FibW'(n_q));
        rd_addr = AW'(base_q);
      end
    end
  end

  // Table memory; writes only happen while idle, so a search never reads
  // an entry that is being written.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx[AW-1:0]] <= wr_val;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= LenReset;
      res_valid_q <= 1'b0;
      res_q       <= '0;
      n_q         <= '0;
      f0_q        <= '0;
      f1_q        <= '0;
      f2_q        <= '0;
      base_q      <= '0;
      idx_q       <= '0;
      key_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      case (state_q)
        S_IDLE: begin
          if (accept && (cmd_i.command == CmdSearch)) begin
            n_q     <= n_new;
            key_q   <= key_ext;
            f0_q    <= FibW'(1);
            f1_q    <= FibW'(1);
            f2_q    <= '0;
            base_q  <= '0;
            state_q <= S_GROW;
          end
        end
        S_GROW: begin
          if (f0_q < FibW'(n_q)) begin
            f2_q <= f1_q;
            f1_q <= f0_q;
            f0_q <= f0_q + f1_q;
          end else begin
            state_q <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (f0_q > FibW'(1)) begin
            idx_q   <= probe_idx;
            state_q <= S_CMP;
          end else if (rd_en) begin
            idx_q   <= XW'(base_q);
            state_q <= S_FINAL;
          end else begin
            res_valid_q <= 1'b1;
            res_q       <= '0;
            state_q     <= S_IDLE;
          end
        end
        S_CMP: begin
          if (rdata_q < key_q) begin
            f0_q    <= f1_q;
            f1_q    <= f2_q;
            f2_q    <= f1_q - f2_q;
            base_q  <= FibW'(idx_q) + FibW'(1);
            state_q <= S_PROBE;
          end else if (rdata_q > key_q) begin
            f0_q    <= f2_q;
            f1_q    <= f1_q - f2_q;
            f2_q    <= f2_q - (f1_q - f2_q);
            state_q <= S_PROBE;
          end else begin
            res_valid_q       <= 1'b1;
            res_q.found       <= 1'b1;
            res_q.found_index <= idx_q[IdxW-1:0];
            state_q           <= S_IDLE;
          end
        end
        S_FINAL: begin
          res_valid_q       <= 1'b1;
          res_q.found       <= (rdata_q == key_q);
          res_q.found_index <= (rdata_q == key_q) ? idx_q[IdxW-1:0] : '0;
          state_q           <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  a_beat_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result beat while a search is running");

  a_search_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i.command == CmdSearch) |=> busy)
    else $error("search accepted but engine not busy");

  a_write_no_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i.command == CmdWrite) |=> (!busy && !result_valid_o))
    else $error("write produced a result or raised busy");

  a_cmp_after_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP || state_q == S_FINAL) |-> $past(state_q) == S_PROBE)
    else $error("compare without a preceding table read");

endmodule

FILE: tb/sv/fse_tb_pkg.sv
`timescale 1ns / 1ps
package fse_tb_pkg;
  import fse_pkg::*;

  localparam int TableDepth = 1 << AddrW;

  class fse_scoreboard;
    logic signed [DataW-1:0] entries [TableDepth];
    logic [LenW-1:0]         length_reg;
    res_t                    expected_q [$];
    int unsigned             error_count;
    int unsigned             search_count;
    int unsigned             write_count;
    int unsigned             hit_count;

    function new();
      length_reg   = LenReset;
      error_count  = 0;
      search_count = 0;
      write_count  = 0;
      hit_count    = 0;
    endfunction

    function void set_length(logic [LenW-1:0] value);
      length_reg = value;
    endfunction

    // Fibonacci probe walk; probes past the end are pulled back to the last entry
    function res_t fib_lookup(logic signed [DataW-1:0] key);
      res_t r;
      int   n;
      int   fib_hi;
      int   fib_mid;
      int   fib_lo;
      int   offset;
      int   idx;
      r = '0;
      n = (length_reg > TableDepth) ? TableDepth : int'(length_reg);
      if (n <= 0) return r;
      fib_lo  = 0;
      fib_mid = 1;
      fib_hi  = 1;
      offset  = -1;
      while (fib_hi < n) begin
        fib_lo  = fib_mid;
        fib_mid = fib_hi;
        fib_hi  = fib_lo + fib_mid;
      end
      while (fib_hi > 1) begin
        idx = offset + fib_lo;
        if (idx > n - 1) idx = n - 1;
        if (idx < 0) idx = 0;
        if (entries[idx] < key) begin
          fib_hi  = fib_mid;
          fib_mid = fib_lo;
          fib_lo  = fib_hi - fib_mid;
          offset  = idx;
        end else if (entries[idx] > key) begin
          fib_hi  = fib_lo;
          fib_mid = fib_mid - fib_lo;
          fib_lo  = fib_hi - fib_mid;
        end else begin
          r.found       = 1'b1;
          r.found_index = idx[IdxW-1:0];
          return r;
        end
      end
      // last look at the entry just past the offset
      if (fib_mid == 1 && offset + 1 >= 0 && offset + 1 < n && entries[offset + 1] == key) begin
        r.found       = 1'b1;
        r.found_index = IdxW'(offset + 1);
      end
      return r;
    endfunction

    function void note_cmd(cmd_t c);
      if (c.command == CmdWrite) begin
        entries[c.entry_address] = c.entry_value;
        write_count++;
      end else begin
        expected_q.push_back(fib_lookup(c.search_key));
        search_count++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with no search outstanding: found=%0b found_index=%0d",
               got.found, got.found_index);
        error_count++;
        return;
      end
      want = expected_q.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0b, got %0b", want.found, got.found);
        error_count++;
      end
      if (got.found_index !== want.found_index) begin
        $error("found_index: expected %0d, got %0d", want.found_index, got.found_index);
        error_count++;
      end
      if (want.found) hit_count++;
    endfunction
  endclass

endpackage

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import fse_pkg::*;
  import fse_tb_pkg::*;

  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned SettleCycles = 64;
  localparam int unsigned SegItems     = 12;
  localparam int          RefillCount  = 40;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  cmd_t            cmd_i;
  logic            cfg_we_i;
  logic [LenW-1:0] cfg_wdata_i;
  logic            result_valid_o;
  res_t            result_o;

  int unsigned   cycle_count = 0;
  int unsigned   idle_pct;
  int unsigned   length_writes;
  fse_scoreboard sb;

  fibonacci_search_engine_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_result(result_o);
  end

  // Holds start high until the beat is taken; random gaps before it
  task automatic send_cmd(cmd_t c);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    cmd_i <= c;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    sb.note_cmd(c);
  endtask

  task automatic write_entry(int addr, logic signed [DataW-1:0] value);
    cmd_t c;
    c.command       = CmdWrite;
    c.entry_address = AddrW'(addr);
    c.entry_value   = value;
    c.search_key    = $urandom;
    send_cmd(c);
  endtask

  task automatic search_for(logic signed [DataW-1:0] key);
    cmd_t c;
    c.command       = CmdSearch;
    c.entry_address = AddrW'($urandom);
    c.entry_value   = $urandom;
    c.search_key    = key;
    send_cmd(c);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_length(logic [LenW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_length(value);
    length_writes++;
  endtask

  // style 0: full signed range, 1: narrow range with long runs of equal values,
  // 2: random base with some repeats; count entries from address 0 are written
  task automatic fill_table(int style, int count);
    longint acc;
    longint step;
    case (style)
      0:       acc = -64'sd2147483648;
      1:       acc = longint'($urandom_range(0, 80)) - 40;
      default: acc = -longint'($urandom_range(0, 32'h7FFF_FFFF));
    endcase
    for (int a = 0; a < count; a++) begin
      if (style == 0 && a == TableDepth - 1) acc = 64'sd2147483647;
      write_entry(a, DataW'(acc));
      case (style)
        0:       step = ($urandom_range(0, 3) == 0) ? 64'sd0
                                                    : longint'($urandom_range(0, 1 << 23));
        1:       step = longint'($urandom_range(0, 1));
        default: step = ($urandom_range(0, 3) == 0) ? 64'sd0
                                                    : longint'($urandom_range(0, 1 << 20));
      endcase
      acc = acc + step;
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    end
  endtask

  // n is the number of entries a search can reach; a length of 0 passes the full table depth
  task automatic random_item(int n);
    longint                  lo;
    longint                  hi;
    longint unsigned         r64;
    int                      a;
    int                      pick;
    logic signed [DataW-1:0] value;
    if ($urandom_range(0, 99) < 35) begin
      a = ($urandom_range(0, 99) < 70) ? int'($urandom_range(0, n - 1))
                                       : int'($urandom_range(0, TableDepth - 1));
      value = $urandom;
      // mostly keep the table sorted; the rest is noise
      if ($urandom_range(0, 99) < 80) begin
        lo = (a > 0) ? longint'(sb.entries[a - 1]) : -64'sd2147483648;
        hi = (a < TableDepth - 1) ? longint'(sb.entries[a + 1]) : 64'sd2147483647;
        if (lo <= hi) begin
          r64   = {$urandom, $urandom};
          value = DataW'(lo + longint'(r64 % (hi - lo + 1)));
        end
      end
      write_entry(a, value);
    end else begin
      pick = int'($urandom_range(0, 99));
      a    = int'($urandom_range(0, n - 1));
      if (pick < 55) value = sb.entries[a];
      else if (pick < 70) value = sb.entries[a] + (($urandom_range(0, 1) == 1) ? 1 : -1);
      else if (pick < 90) value = $urandom;
      else begin
        case ($urandom_range(0, 3))
          0:       value = 32'sh8000_0000;
          1:       value = 32'sh7FFF_FFFF;
          2:       value = '0;
          default: value = '1;
        endcase
      end
      search_for(value);
    end
  endtask

  initial begin
    int              dup;
    int              eff;
    logic [LenW-1:0] len_val;
    sb            = new();
    idle_pct      = 19;
    length_writes = 0;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    cmd_i       <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    fill_table(0, TableDepth);

    // directed: length left at its reset value
    dup = 0;
    for (int a = 0; a < TableDepth - 1; a++) begin
      if (dup == 0 && sb.entries[a] == sb.entries[a + 1]) dup = a + 1;
    end
    search_for(sb.entries[0]);
    search_for(sb.entries[TableDepth - 1]);
    search_for(sb.entries[TableDepth / 2 - 1]);
    search_for(sb.entries[dup]);
    search_for(sb.entries[100] + 1);
    search_for('0);
    search_for('1);
    search_for(32'sh7FFF_FFFE);
    write_entry(0, 32'sh8000_0000);
    write_entry(TableDepth - 1, 32'sh7FFF_FFFF);
    search_for(32'sh8000_0000);
    search_for(32'sh7FFF_FFFF);
    write_entry(TableDepth / 2, sb.entries[TableDepth / 2 + 1]);
    search_for(sb.entries[TableDepth / 2]);

    for (int p = 0; p < 3; p++) begin
      idle_pct = (p == 0) ? 19 : (p == 1) ? 78 : 0;
      if (p != 0) fill_table(p, RefillCount);
      for (int s = 0; s < 4; s++) begin
        wait_idle();
        case (p * 4 + s)
          0:       len_val = LenW'(1);
          1:       len_val = LenW'(2047);
          2:       len_val = LenW'($urandom_range(4, 40));
          3:       len_val = LenW'(0);
          4:       len_val = LenW'(1024);
          5:       len_val = LenW'(2);
          6:       len_val = LenW'($urandom_range(1, 1024));
          7:       len_val = LenW'(1023);
          8:       len_val = LenW'(3);
          9:       len_val = LenW'($urandom_range(5, 64));
          10:      len_val = LenW'($urandom_range(1, 1024));
          default: len_val = LenW'(1024);
        endcase
        write_length(len_val);
        eff = (len_val == 0 || len_val > TableDepth) ? TableDepth : int'(len_val);
        repeat (SegItems) random_item(eff);
      end
    end

    wait_idle();
    $display("Covered %0d searches (%0d hits) and %0d table writes over %0d length settings",
             sb.search_count, sb.hit_count, sb.write_count, length_writes);
    $display("Sender gaps at 19%%, 78%% and none; sorted, run-heavy and partly unsorted tables");
    if (sb.error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
